### rtl/core/arpc_pkg.sv
// ----------------------------------------------------------------------------
// arpc_pkg
// Shared types and constants of the ARP cache: command codes, field widths
// and the layout of one table entry as it is held in memory.
// ----------------------------------------------------------------------------
package arpc_pkg;

    localparam int unsigned ENTRIES_DEFAULT = 128;

    localparam int unsigned CMD_W = 2;
    localparam int unsigned IP_W  = 32;
    localparam int unsigned MAC_W = 48;
    localparam int unsigned AGE_W = 8;

    typedef logic [CMD_W-1:0] cmd_t;

    localparam cmd_t CMD_LOOKUP = 2'd0;
    localparam cmd_t CMD_INSERT = 2'd1;
    localparam cmd_t CMD_TICK   = 2'd2;

    localparam logic [AGE_W-1:0] AGE_MAX       = 8'd255;
    localparam logic [AGE_W-1:0] TIMEOUT_RESET = 8'd15;

    typedef struct packed {
        logic             valid;
        logic [IP_W-1:0]  ip;
        logic [MAC_W-1:0] mac;
        logic [AGE_W-1:0] age;
    } entry_t;

    localparam int unsigned ENTRY_W = $bits(entry_t);

endpackage

### rtl/core/arpc_ram.sv
// ----------------------------------------------------------------------------
// arpc_ram
// Simple dual-port RAM: one write port, one read port, registered read data.
// ----------------------------------------------------------------------------
module arpc_ram #(
    parameter int unsigned WIDTH = 8,
    parameter int unsigned DEPTH = 16
) (
    input  logic                     aclk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

### rtl/core/arp_cache_table_with_aging.sv
// ----------------------------------------------------------------------------
// arp_cache_table_with_aging
// IPv4 to MAC address table with lookup, insert and per-tick ageing.
// ----------------------------------------------------------------------------
// All ENTRIES slots (valid bit, IP, MAC, age) live in one memory with a
// single read and a single write port, and lookup, insert and tick commands
// walk it one entry per cycle. After reset a clearing pass zeroes the table;
// s_ready stays low meanwhile, configuration writes are still taken. A lookup
// or a tick then walks every slot, an insert stops at the first free slot,
// and an unused command goes straight to its result without a walk. The
// memory read port sets the pace of the walk. A new command is taken
// while the previous result still waits on the m_ channel. Write
// timeout_ticks through the cfg_ channel only while the block is idle.
// ----------------------------------------------------------------------------
module arp_cache_table_with_aging #(
    parameter int unsigned ENTRIES = arpc_pkg::ENTRIES_DEFAULT
) (
    input  logic                       aclk,
    input  logic                       aresetn,

    input  logic                       s_valid,
    output logic                       s_ready,
    input  logic [arpc_pkg::CMD_W-1:0] s_command,
    input  logic [arpc_pkg::IP_W-1:0]  s_ip_addr,
    input  logic [arpc_pkg::MAC_W-1:0] s_mac_addr,

    output logic                       m_valid,
    input  logic                       m_ready,
    output logic                       m_hit,
    output logic [arpc_pkg::MAC_W-1:0] m_found_mac,
    output logic                       m_status,

    input  logic                       cfg_valid,
    output logic                       cfg_ready,
    input  logic [arpc_pkg::AGE_W-1:0] cfg_data
);

    localparam int unsigned AW = $clog2(ENTRIES);
    localparam logic [AW-1:0] LAST = AW'(ENTRIES - 1);

    typedef enum logic [1:0] {
        S_CLEAR,
        S_IDLE,
        S_SCAN,
        S_FINISH
    } state_t;

    state_t                     state_reg, state_next;
    logic [AW-1:0]              addr_reg, addr_next;
    logic                       issue_reg, issue_next;
    logic                       rvalid_reg, rvalid_next;
    logic [AW-1:0]              ridx_reg, ridx_next;
    logic                       m_valid_reg, m_valid_next;
    logic [arpc_pkg::AGE_W-1:0] timeout_reg, timeout_next;

    arpc_pkg::cmd_t             cmd_reg, cmd_next;
    logic [arpc_pkg::IP_W-1:0]  ip_reg, ip_next;
    logic [arpc_pkg::MAC_W-1:0] mac_reg, mac_next;
    logic                       hit_reg, hit_next;
    logic [arpc_pkg::MAC_W-1:0] found_reg, found_next;
    logic                       status_reg, status_next;
    logic                       m_hit_reg, m_hit_next;
    logic [arpc_pkg::MAC_W-1:0] m_found_reg, m_found_next;
    logic                       m_status_reg, m_status_next;

    logic                       ram_we;
    logic [AW-1:0]              ram_waddr;
    logic [arpc_pkg::ENTRY_W-1:0] ram_wdata;
    logic [arpc_pkg::ENTRY_W-1:0] ram_rdata;

    arpc_pkg::entry_t           rd_entry;
    arpc_pkg::entry_t           wr_entry;
    logic [arpc_pkg::AGE_W-1:0] age_inc;

    // Reads run one entry ahead of writes, so a write never meets a read of
    // the same slot and no forwarding is needed.
    arpc_ram #(
        .WIDTH (arpc_pkg::ENTRY_W),
        .DEPTH (ENTRIES)
    ) u_table (
        .aclk  (aclk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .raddr (addr_reg),
        .rdata (ram_rdata)
    );

    assign rd_entry = arpc_pkg::entry_t'(ram_rdata);
    assign age_inc  = (rd_entry.age == arpc_pkg::AGE_MAX) ? rd_entry.age
                                                          : rd_entry.age + 8'd1;

    always_comb begin
        state_next    = state_reg;
        addr_next     = addr_reg;
        issue_next    = issue_reg;
        rvalid_next   = 1'b0;
        ridx_next     = ridx_reg;
        m_valid_next  = m_valid_reg;
        timeout_next  = timeout_reg;
        cmd_next      = cmd_reg;
        ip_next       = ip_reg;
        mac_next      = mac_reg;
        hit_next      = hit_reg;
        found_next    = found_reg;
        status_next   = status_reg;
        m_hit_next    = m_hit_reg;
        m_found_next  = m_found_reg;
        m_status_next = m_status_reg;
        ram_we        = 1'b0;
        ram_waddr     = ridx_reg;
        wr_entry      = '0;

        if (cfg_valid) begin
            timeout_next = cfg_data;
        end

        if (m_valid_reg && m_ready) begin
            m_valid_next = 1'b0;
        end

        case (state_reg)
            S_CLEAR: begin
                ram_we    = 1'b1;
                ram_waddr = addr_reg;
                addr_next = addr_reg + 1'b1;
                if (addr_reg == LAST) begin
                    addr_next  = '0;
                    state_next = S_IDLE;
                end
            end
            S_IDLE: begin
                if (s_valid) begin
                    cmd_next    = s_command;
                    ip_next     = s_ip_addr;
                    mac_next    = s_mac_addr;
                    hit_next    = 1'b0;
                    found_next  = '0;
                    status_next = 1'b0;
                    addr_next   = '0;
                    issue_next  = 1'b1;
                    if (s_command inside {arpc_pkg::CMD_LOOKUP, arpc_pkg::CMD_INSERT,
                                          arpc_pkg::CMD_TICK}) begin
                        state_next = S_SCAN;
                    end else begin
                        state_next = S_FINISH;
                    end
                end
            end
            S_SCAN: begin
                if (issue_reg) begin
                    rvalid_next = 1'b1;
                    ridx_next   = addr_reg;
                    addr_next   = addr_reg + 1'b1;
                    if (addr_reg == LAST) begin
                        issue_next = 1'b0;
                    end
                end
                if (rvalid_reg) begin
                    case (cmd_reg)
                        arpc_pkg::CMD_LOOKUP: begin
                            // later matches overwrite, so the highest index wins
                            if (rd_entry.valid && rd_entry.ip == ip_reg) begin
                                hit_next   = 1'b1;
                                found_next = rd_entry.mac;
                            end
                            if (ridx_reg == LAST) begin
                                state_next = S_FINISH;
                            end
                        end
                        arpc_pkg::CMD_INSERT: begin
                            if (!rd_entry.valid) begin
                                wr_entry.valid = 1'b1;
                                wr_entry.ip    = ip_reg;
                                wr_entry.mac   = mac_reg;
                                wr_entry.age   = '0;
                                ram_we         = 1'b1;
                                state_next     = S_FINISH;
                                issue_next     = 1'b0;
                            end else if (ridx_reg == LAST) begin
                                status_next = 1'b1;
                                state_next  = S_FINISH;
                            end
                        end
                        arpc_pkg::CMD_TICK: begin
                            if (rd_entry.valid) begin
                                wr_entry.valid = !(age_inc > timeout_reg);
                                wr_entry.ip    = rd_entry.ip;
                                wr_entry.mac   = rd_entry.mac;
                                wr_entry.age   = age_inc;
                                ram_we         = 1'b1;
                            end
                            if (ridx_reg == LAST) begin
                                state_next = S_FINISH;
                            end
                        end
                        default: begin
                            state_next = S_FINISH;
                        end
                    endcase
                end
            end
            S_FINISH: begin
                // hold the result until the output register is free
                if (!m_valid_reg || m_ready) begin
                    m_valid_next  = 1'b1;
                    m_hit_next    = hit_reg;
                    m_found_next  = found_reg;
                    m_status_next = status_reg;
                    state_next    = S_IDLE;
                end
            end
            default: begin
                state_next = S_IDLE;
            end
        endcase

        ram_wdata = wr_entry;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg    <= S_CLEAR;
            addr_reg     <= '0;
            issue_reg    <= 1'b0;
            rvalid_reg   <= 1'b0;
            m_valid_reg  <= 1'b0;
            timeout_reg  <= arpc_pkg::TIMEOUT_RESET;
        end else begin
            state_reg    <= state_next;
            addr_reg     <= addr_next;
            issue_reg    <= issue_next;
            rvalid_reg   <= rvalid_next;
            m_valid_reg  <= m_valid_next;
            timeout_reg  <= timeout_next;
        end
    end

    always_ff @(posedge aclk) begin
        ridx_reg     <= ridx_next;
        cmd_reg      <= cmd_next;
        ip_reg       <= ip_next;
        mac_reg      <= mac_next;
        hit_reg      <= hit_next;
        found_reg    <= found_next;
        status_reg   <= status_next;
        m_hit_reg    <= m_hit_next;
        m_found_reg  <= m_found_next;
        m_status_reg <= m_status_next;
    end

    assign s_ready     = (state_reg == S_IDLE);
    assign cfg_ready   = 1'b1;
    assign m_valid     = m_valid_reg;
    assign m_hit       = m_hit_reg;
    assign m_found_mac = m_found_reg;
    assign m_status    = m_status_reg;

endmodule

### rtl/core/arpc_checker.sv
// ----------------------------------------------------------------------------
// arpc_checker
// Port-level checks of the ARP cache: result consistency and item count.
// ----------------------------------------------------------------------------
module arpc_checker (
    input logic                       aclk,
    input logic                       aresetn,
    input logic                       s_valid,
    input logic                       s_ready,
    input logic                       m_valid,
    input logic                       m_ready,
    input logic                       m_hit,
    input logic [arpc_pkg::MAC_W-1:0] m_found_mac,
    input logic                       m_status
);

    // items taken in whose result has not yet been transferred
    logic [1:0] open_reg, open_next;

    always_comb begin
        open_next = open_reg;
        if ((s_valid && s_ready) && !(m_valid && m_ready)) begin
            open_next = open_reg + 2'd1;
        end else if (!(s_valid && s_ready) && (m_valid && m_ready)) begin
            open_next = open_reg - 2'd1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            open_reg <= '0;
        end else begin
            open_reg <= open_next;
        end
    end

    a_result_held: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> m_valid && $stable(m_hit) && $stable(m_found_mac)
                                && $stable(m_status))
        else $error("result changed while stalled");

    a_hit_xor_full: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid |-> !(m_hit && m_status))
        else $error("hit and full flagged together");

    a_miss_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_hit |-> m_found_mac == '0)
        else $error("nonzero MAC on a miss");

    a_item_count: assert property (@(posedge aclk) disable iff (!aresetn)
        (open_reg != 2'd3) && (!(m_valid && m_ready) || (open_reg != 2'd0)))
        else $error("result without an item, or too many items open");

endmodule

bind arp_cache_table_with_aging arpc_checker u_arpc_checker (
    .aclk        (aclk),
    .aresetn     (aresetn),
    .s_valid     (s_valid),
    .s_ready     (s_ready),
    .m_valid     (m_valid),
    .m_ready     (m_ready),
    .m_hit       (m_hit),
    .m_found_mac (m_found_mac),
    .m_status    (m_status)
);

### test/testbench.sv
// ----------------------------------------------------------------------------
// ARP cache table with ageing - block-level testbench
// Drives lookup, insert, tick and unused commands through the s_ channel,
// predicts every reply from a private copy of the table and the timeout
// register, and compares each m_ transfer field by field. Covers an empty
// table, duplicate inserts, a full table, timeouts at both extremes and a
// long result stall that backs the block up.
// ----------------------------------------------------------------------------
module testbench;

    timeunit 1ns;
    timeprecision 1ps;

    localparam int unsigned ENTRIES        = arpc_pkg::ENTRIES_DEFAULT;
    localparam int unsigned HOLD_CYCLES    = 600;
    localparam int unsigned WATCHDOG_LIMIT = 4000;
    localparam int unsigned PRINT_CAP      = 40;

    // the command field has one code the block does not act on
    localparam arpc_pkg::cmd_t CMD_UNUSED = 2'd3;

    typedef struct packed {
        logic                       hit;
        logic [arpc_pkg::MAC_W-1:0] mac;
        logic                       status;
    } arp_reply_t;

    logic                       aclk = 1'b0;
    logic                       aresetn = 1'b0;
    logic                       s_valid = 1'b0;
    logic                       s_ready;
    arpc_pkg::cmd_t             s_command = arpc_pkg::CMD_LOOKUP;
    logic [arpc_pkg::IP_W-1:0]  s_ip_addr = '0;
    logic [arpc_pkg::MAC_W-1:0] s_mac_addr = '0;
    logic                       m_valid;
    logic                       m_ready = 1'b0;
    logic                       m_hit;
    logic [arpc_pkg::MAC_W-1:0] m_found_mac;
    logic                       m_status;
    logic                       cfg_valid = 1'b0;
    logic                       cfg_ready;
    logic [arpc_pkg::AGE_W-1:0] cfg_data = '0;

    // shadow of the table and of the timeout register
    logic                       tbl_valid [ENTRIES];
    logic [arpc_pkg::IP_W-1:0]  tbl_ip    [ENTRIES];
    logic [arpc_pkg::MAC_W-1:0] tbl_mac   [ENTRIES];
    logic [arpc_pkg::AGE_W-1:0] tbl_age   [ENTRIES];
    logic [arpc_pkg::AGE_W-1:0] ttl_limit;

    arp_reply_t  reply_q [$];
    int unsigned error_count = 0;
    int unsigned burst_left = 0;
    int unsigned hold_seq = 0;

    arp_cache_table_with_aging #(
        .ENTRIES (ENTRIES)
    ) dut (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .s_valid     (s_valid),
        .s_ready     (s_ready),
        .s_command   (s_command),
        .s_ip_addr   (s_ip_addr),
        .s_mac_addr  (s_mac_addr),
        .m_valid     (m_valid),
        .m_ready     (m_ready),
        .m_hit       (m_hit),
        .m_found_mac (m_found_mac),
        .m_status    (m_status),
        .cfg_valid   (cfg_valid),
        .cfg_ready   (cfg_ready),
        .cfg_data    (cfg_data)
    );

    always begin
        #4ns aclk = 1'b1;
        #4ns aclk = 1'b0;
    end

    // ------------------------------------------------------------------------
    // Reply prediction
    // ------------------------------------------------------------------------
    function automatic arp_reply_t resolve_command(arpc_pkg::cmd_t cmd,
                                                   logic [arpc_pkg::IP_W-1:0] ip,
                                                   logic [arpc_pkg::MAC_W-1:0] mac);
        arp_reply_t r;
        bit         placed;
        int         i;
        r = '0;
        placed = 1'b0;
        case (cmd)
            arpc_pkg::CMD_LOOKUP: begin
                // highest matching index wins
                for (i = 0; i < ENTRIES; i++) begin
                    if (tbl_valid[i] && tbl_ip[i] == ip) begin
                        r.hit = 1'b1;
                        r.mac = tbl_mac[i];
                    end
                end
            end
            arpc_pkg::CMD_INSERT: begin
                for (i = 0; i < ENTRIES && !placed; i++) begin
                    if (!tbl_valid[i]) begin
                        tbl_valid[i] = 1'b1;
                        tbl_ip[i]    = ip;
                        tbl_mac[i]   = mac;
                        tbl_age[i]   = '0;
                        placed       = 1'b1;
                    end
                end
                r.status = !placed;
            end
            arpc_pkg::CMD_TICK: begin
                for (i = 0; i < ENTRIES; i++) begin
                    if (tbl_valid[i]) begin
                        if (tbl_age[i] < arpc_pkg::AGE_MAX)
                            tbl_age[i] = tbl_age[i] + 1'b1;
                        if (tbl_age[i] > ttl_limit)
                            tbl_valid[i] = 1'b0;
                    end
                end
            end
            default: ;
        endcase
        return r;
    endfunction

    task automatic report_mismatch(string what, logic [63:0] got, logic [63:0] want);
        error_count++;
        if (error_count <= PRINT_CAP)
            $display("%0t ns ERROR %s: got %0h, expected %0h", $time, what, got, want);
    endtask

    // Track transfers on all three channels; pop before push so a reply
    // never meets the item accepted on the same edge.
    always @(posedge aclk) begin
        arp_reply_t want;
        if (!aresetn) begin
            ttl_limit = arpc_pkg::TIMEOUT_RESET;
            for (int i = 0; i < ENTRIES; i++) begin
                tbl_valid[i] = 1'b0;
                tbl_ip[i]    = '0;
                tbl_mac[i]   = '0;
                tbl_age[i]   = '0;
            end
            reply_q.delete();
        end else begin
            if (m_valid && m_ready) begin
                if (reply_q.size() == 0) begin
                    report_mismatch("result with nothing pending",
                                    64'({m_hit, m_found_mac, m_status}), 64'd0);
                end else begin
                    want = reply_q.pop_front();
                    if (m_hit !== want.hit)
                        report_mismatch("hit", 64'(m_hit), 64'(want.hit));
                    if (m_found_mac !== want.mac)
                        report_mismatch("found_mac", 64'(m_found_mac), 64'(want.mac));
                    if (m_status !== want.status)
                        report_mismatch("status", 64'(m_status), 64'(want.status));
                end
            end
            if (s_valid && s_ready)
                reply_q.push_back(resolve_command(s_command, s_ip_addr, s_mac_addr));
            if (cfg_valid && cfg_ready)
                ttl_limit = cfg_data;
        end
    end

    // ------------------------------------------------------------------------
    // Result side: changing stall patterns, plus a single long hold-off
    // ------------------------------------------------------------------------
    initial begin : result_sink
        int unsigned hold_seen;
        int unsigned mode;
        int unsigned span;
        int unsigned stall_left;
        int unsigned phase;
        hold_seen = 0;
        mode = 0;
        span = 0;
        stall_left = 0;
        phase = 0;
        forever begin
            @(posedge aclk);
            phase++;
            if (hold_seq != hold_seen) begin
                hold_seen = hold_seq;
                m_ready <= 1'b0;
                repeat (HOLD_CYCLES) @(posedge aclk);
            end else begin
                if (span == 0) begin
                    mode = $urandom_range(0, 3);
                    span = $urandom_range(20, 300);
                end
                span--;
                case (mode)
                    0: m_ready <= 1'b1;
                    1: m_ready <= ($urandom_range(0, 2) != 0);
                    2: begin
                        if (stall_left != 0) begin
                            stall_left--;
                            m_ready <= 1'b0;
                        end else if ($urandom_range(0, 7) == 0) begin
                            stall_left = $urandom_range(1, 6);
                            m_ready <= 1'b0;
                        end else begin
                            m_ready <= 1'b1;
                        end
                    end
                    default: m_ready <= (phase % 4 != 3);
                endcase
            end
        end
    end

    // abort when no channel has moved for too long
    initial begin : watchdog
        int unsigned idle_run;
        idle_run = 0;
        while (idle_run < WATCHDOG_LIMIT) begin
            @(posedge aclk);
            if ((s_valid && s_ready) || (m_valid && m_ready) || (cfg_valid && cfg_ready))
                idle_run = 0;
            else
                idle_run++;
        end
        $display("Verification failed");
        $finish;
    end

    // ------------------------------------------------------------------------
    // Stimulus helpers
    // ------------------------------------------------------------------------
    task automatic send_item(arpc_pkg::cmd_t cmd, logic [arpc_pkg::IP_W-1:0] ip,
                             logic [arpc_pkg::MAC_W-1:0] mac);
        int unsigned gap;
        if (burst_left == 0) begin
            burst_left = $urandom_range(1, 12);
            gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
            if (gap != 0) begin
                s_valid <= 1'b0;
                repeat (gap) @(posedge aclk);
            end
        end
        burst_left--;
        s_valid    <= 1'b1;
        s_command  <= cmd;
        s_ip_addr  <= ip;
        s_mac_addr <= mac;
        @(posedge aclk);
        while (!s_ready) @(posedge aclk);
    endtask

    // lower valid and wait until every reply has come back
    task automatic drain_results();
        s_valid <= 1'b0;
        while (reply_q.size() != 0) @(posedge aclk);
        repeat (4) @(posedge aclk);
    endtask

    task automatic set_timeout(logic [arpc_pkg::AGE_W-1:0] ticks);
        drain_results();
        cfg_valid <= 1'b1;
        cfg_data  <= ticks;
        @(posedge aclk);
        while (!cfg_ready) @(posedge aclk);
        cfg_valid <= 1'b0;
    endtask

    function automatic logic [arpc_pkg::IP_W-1:0] random_ip();
        case ($urandom_range(0, 15))
            0:       return '0;
            1:       return '1;
            default: return $urandom();
        endcase
    endfunction

    function automatic logic [arpc_pkg::MAC_W-1:0] random_mac();
        logic [63:0] w;
        w = {$urandom(), $urandom()};
        return w[arpc_pkg::MAC_W-1:0];
    endfunction

    // IP of a random live entry, or the fallback on an empty table
    function automatic logic [arpc_pkg::IP_W-1:0] live_ip(
        logic [arpc_pkg::IP_W-1:0] fallback);
        int unsigned live;
        int unsigned pick;
        live = 0;
        for (int i = 0; i < ENTRIES; i++)
            if (tbl_valid[i]) live++;
        if (live == 0)
            return fallback;
        pick = $urandom_range(0, live - 1);
        for (int i = 0; i < ENTRIES; i++) begin
            if (tbl_valid[i]) begin
                if (pick == 0)
                    return tbl_ip[i];
                pick--;
            end
        end
        return fallback;
    endfunction

    task automatic run_traffic(int unsigned count, int unsigned w_lookup,
                               int unsigned w_insert, int unsigned w_tick,
                               int unsigned w_unused);
        int unsigned                n;
        int unsigned                roll;
        arpc_pkg::cmd_t             cmd;
        logic [arpc_pkg::IP_W-1:0]  ip;
        logic [arpc_pkg::MAC_W-1:0] mac;
        for (n = 0; n < count; n++) begin
            roll = $urandom_range(0, w_lookup + w_insert + w_tick + w_unused - 1);
            ip   = random_ip();
            mac  = random_mac();
            if (roll < w_lookup) begin
                cmd = arpc_pkg::CMD_LOOKUP;
                if ($urandom_range(0, 3) != 0)
                    ip = live_ip(ip);
            end else if (roll < w_lookup + w_insert) begin
                cmd = arpc_pkg::CMD_INSERT;
                if ($urandom_range(0, 4) == 0)
                    ip = live_ip(ip);
            end else if (roll < w_lookup + w_insert + w_tick) begin
                cmd = arpc_pkg::CMD_TICK;
            end else begin
                cmd = CMD_UNUSED;
            end
            send_item(cmd, ip, mac);
        end
    endtask

    // ------------------------------------------------------------------------
    // Tests
    // ------------------------------------------------------------------------
    task automatic test_empty_table();
        send_item(arpc_pkg::CMD_LOOKUP, '0, '0);
        send_item(arpc_pkg::CMD_LOOKUP, '1, '1);
        send_item(CMD_UNUSED, '1, '1);
    endtask

    task automatic test_insert_and_match();
        send_item(arpc_pkg::CMD_INSERT, '0, '1);
        send_item(arpc_pkg::CMD_INSERT, '1, '0);
        send_item(arpc_pkg::CMD_LOOKUP, '0, '0);
        send_item(arpc_pkg::CMD_LOOKUP, '1, '1);
        // a duplicate IP makes a second entry; the later one must answer
        send_item(arpc_pkg::CMD_INSERT, 32'h0a00_0001, 48'h0200_0000_0001);
        send_item(arpc_pkg::CMD_INSERT, 32'h0a00_0001, 48'h0200_0000_0002);
        send_item(arpc_pkg::CMD_LOOKUP, 32'h0a00_0001, '1);
        send_item(arpc_pkg::CMD_TICK, '1, '1);
        send_item(arpc_pkg::CMD_LOOKUP, 32'h0a00_0002, '0);
    endtask

    task automatic test_timeout_edges();
        // zero: gone on the first tick after the insert
        set_timeout('0);
        send_item(arpc_pkg::CMD_INSERT, 32'hc0a8_0101, 48'h0011_2233_4455);
        send_item(arpc_pkg::CMD_TICK, '0, '0);
        send_item(arpc_pkg::CMD_LOOKUP, 32'hc0a8_0101, '0);
        set_timeout(8'd1);
        send_item(arpc_pkg::CMD_INSERT, 32'hc0a8_0102, 48'hfeed_face_cafe);
        send_item(arpc_pkg::CMD_TICK, '0, '0);
        send_item(arpc_pkg::CMD_LOOKUP, 32'hc0a8_0102, '0);
        send_item(arpc_pkg::CMD_TICK, '0, '0);
        send_item(arpc_pkg::CMD_LOOKUP, 32'hc0a8_0102, '0);
    endtask

    task automatic test_table_full();
        set_timeout(8'd254);
        run_traffic(300, 30, 65, 2, 3);
    endtask

    task automatic test_age_saturation();
        // ages pin at the top and nothing may expire
        set_timeout(arpc_pkg::AGE_MAX);
        run_traffic(300, 4, 0, 95, 1);
    endtask

    task automatic test_backpressure();
        set_timeout(8'd6);
        hold_seq++;
        // keep valid up throughout so the block fills and stalls its input
        burst_left = 1000;
        run_traffic(80, 20, 40, 10, 30);
        burst_left = 0;
    endtask

    task automatic test_random_mix();
        logic [arpc_pkg::AGE_W-1:0] ticks;
        for (int phase = 0; phase < 8; phase++) begin
            case (phase)
                0:       ticks = 8'd254;
                1:       ticks = 8'd2;
                2:       ticks = 8'd40;
                default: ticks = arpc_pkg::AGE_W'($urandom_range(0, 255));
            endcase
            set_timeout(ticks);
            run_traffic(145, 40, 30, 22, 8);
        end
    endtask

    initial begin : sequencer
        repeat (3) @(posedge aclk);
        aresetn <= 1'b1;
        test_empty_table();
        test_insert_and_match();
        test_timeout_edges();
        test_table_full();
        test_age_saturation();
        test_backpressure();
        test_random_mix();
        drain_results();
        repeat (ENTRIES + 8) @(posedge aclk);
        if (reply_q.size() != 0)
            report_mismatch("results never delivered", 64'(reply_q.size()), 64'd0);
        if (error_count == 0)
            $display("Verification passed");
        else
            $display("Verification failed");
        $finish;
    end

endmodule
